// ----- hdl/greedy_edge_coloring_top_defines.svh -----
// Assertion macros shared by the edge colouring RTL.
// No dependencies; taken in by `include where checks are written.
`ifndef GREEDY_EDGE_COLORING_TOP_DEFINES_SVH
`define GREEDY_EDGE_COLORING_TOP_DEFINES_SVH

// Same-cycle implication, masked while reset is held.
`define GEC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, masked while reset is held.
`define GEC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/gec_pkg.sv -----
// Shared types and constants of the greedy edge colouring block.
// No dependencies; used by the interfaces and every module.
package gec_pkg;

    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_COLORS_DEF   = 127;

    localparam int VERTEX_W = 6;
    localparam int OUT_W    = 7;
    localparam int STATUS_W = 2;

    localparam int QUEUE_DEPTH = 2;

    typedef enum logic {
        CMD_CLEAR = 1'b0,
        CMD_COLOR = 1'b1
    } t_command;

    typedef enum logic [STATUS_W-1:0] {
        ST_COLORED  = 2'd0,
        ST_CLEARED  = 2'd1,
        ST_REJECTED = 2'd2
    } t_status;

    // Classification made by the front end.
    typedef enum logic [1:0] {
        K_EDGE,
        K_CLEAR,
        K_REJECT
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [VERTEX_W-1:0] vertex_a;
        logic [VERTEX_W-1:0] vertex_b;
    } t_op;

endpackage

// ----- hdl/gec_in_if.sv -----
// Edge command channel: valid/ready plus command and vertex pair.
// Depends on gec_pkg.
interface gec_in_if;
    logic                         valid;
    logic                         ready;
    logic                         command;
    logic [gec_pkg::VERTEX_W-1:0] vertex_a;
    logic [gec_pkg::VERTEX_W-1:0] vertex_b;

    modport source (output valid, command, vertex_a, vertex_b, input ready);
    modport sink   (input valid, command, vertex_a, vertex_b, output ready);
endinterface

// ----- hdl/gec_out_if.sv -----
// Result channel: valid/ready plus colour, chromatic index and status.
// Depends on gec_pkg.
interface gec_out_if;
    logic                         valid;
    logic                         ready;
    logic [gec_pkg::OUT_W-1:0]    edge_color;
    logic [gec_pkg::OUT_W-1:0]    chromatic_index;
    logic [gec_pkg::STATUS_W-1:0] status;

    modport source (output valid, edge_color, chromatic_index, status, input ready);
    modport sink   (input valid, edge_color, chromatic_index, status, output ready);
endinterface

// ----- hdl/gec_front.sv -----
// Front end: takes edge commands and sorts them into clear, edge or reject.
// Depends on gec_pkg and gec_in_if.
module gec_front #(
    parameter int MAX_VERTICES = gec_pkg::MAX_VERTICES_DEF
) (
    gec_in_if.sink         i_edge,
    output logic           o_op_vld,
    output gec_pkg::t_op   o_op,
    input  logic           i_op_rdy
);

    logic bad_pair;

    // self loop or vertex past the table
    assign bad_pair = (i_edge.vertex_a == i_edge.vertex_b)
                   || (32'(i_edge.vertex_a) >= MAX_VERTICES)
                   || (32'(i_edge.vertex_b) >= MAX_VERTICES);

    always_comb begin
        o_op.vertex_a = i_edge.vertex_a;
        o_op.vertex_b = i_edge.vertex_b;
        if (i_edge.command == gec_pkg::CMD_CLEAR) begin
            o_op.kind = gec_pkg::K_CLEAR;
        end else if (bad_pair) begin
            o_op.kind = gec_pkg::K_REJECT;
        end else begin
            o_op.kind = gec_pkg::K_EDGE;
        end
    end

    assign o_op_vld     = i_edge.valid;
    assign i_edge.ready = i_op_rdy;

endmodule

// ----- hdl/gec_queue.sv -----
// Short FIFO of classified operations between front and back end.
// Depends on gec_pkg.
module gec_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push_vld,
    input  gec_pkg::t_op i_push_op,
    output logic         o_push_rdy,
    output logic         o_pop_vld,
    output gec_pkg::t_op o_pop_op,
    input  logic         i_pop_rdy
);

    localparam int DEPTH = gec_pkg::QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW  = $clog2(DEPTH + 1);

    gec_pkg::t_op    r_slot [DEPTH];
    logic [PW-1:0]   r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]   r_rd_ptr, n_rd_ptr;
    logic [CNTW-1:0] r_count,  n_count;
    logic            push, pop;

    assign o_push_rdy = (r_count != CNTW'(DEPTH));
    assign o_pop_vld  = (r_count != '0);
    assign o_pop_op   = r_slot[r_rd_ptr];
    assign push       = i_push_vld && o_push_rdy;
    assign pop        = o_pop_vld && i_pop_rdy;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (push && !pop) begin
            n_count = r_count + CNTW'(1);
        end else if (pop && !push) begin
            n_count = r_count - CNTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_slot[r_wr_ptr] <= i_push_op;
        end
    end

endmodule

// ----- hdl/gec_back.sv -----
// Back end: bitmap memory, first-fit colour search, write-back, result register.
// Depends on gec_pkg, gec_out_if and the assertion macro header.
`include "greedy_edge_coloring_top_defines.svh"

module gec_back #(
    parameter int MAX_VERTICES = gec_pkg::MAX_VERTICES_DEF,
    parameter int MAX_COLORS   = gec_pkg::MAX_COLORS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_op_vld,
    input  gec_pkg::t_op i_op,
    output logic         o_op_rdy,
    gec_out_if.source    o_result
);

    localparam int AW   = $clog2(MAX_VERTICES);
    localparam int CW   = $clog2(MAX_COLORS + 1);
    localparam int GRP  = 16;
    localparam int GIW  = $clog2(GRP);
    localparam int NG   = (MAX_COLORS + GRP - 1) / GRP;
    localparam int NGW  = (NG > 1) ? $clog2(NG) : 1;
    localparam int PADW = NG * GRP;
    localparam int OW   = gec_pkg::OUT_W;

    // bitmap store, one row per vertex
    logic [MAX_COLORS-1:0] mem [MAX_VERTICES];
    logic [MAX_COLORS-1:0] r_rd_a, r_rd_b;
    logic                  wr_en;
    logic [AW-1:0]         wr_addr;
    logic [MAX_COLORS-1:0] wr_data;

    logic [MAX_VERTICES-1:0] r_row_vld, n_row_vld;

    // issue
    logic pop;

    // read stage
    logic          r_s1_vld, n_s1_vld;
    gec_pkg::t_kind r_s1_kind;
    logic [AW-1:0] r_s1_a, r_s1_b;
    logic [MAX_COLORS-1:0] s1_row_a, s1_row_b, s1_free;
    logic [PADW-1:0]       s1_free_pad;
    logic                  grp_any [NG];
    logic [GIW-1:0]        grp_idx [NG];
    logic                  s1_go;

    // resolve stage
    logic          r_s2_vld, n_s2_vld;
    gec_pkg::t_kind r_s2_kind;
    logic [AW-1:0] r_s2_a, r_s2_b;
    logic [MAX_COLORS-1:0] r_s2_row_a, r_s2_row_b;
    logic                  r_s2_any [NG];
    logic [GIW-1:0]        r_s2_idx [NG];
    logic                  s2_found;
    logic [NGW-1:0]        s2_sel;
    logic [NGW+GIW-1:0]    s2_color_m1;
    logic [CW-1:0]         s2_color;
    logic [MAX_COLORS-1:0] s2_mask;
    logic                  s2_go, commit_edge, commit_clear;

    // second row write and forwarding of the last written pair
    logic                  r_s3_vld, n_s3_vld;
    logic                  r_fwd_vld, n_fwd_vld;
    logic [AW-1:0]         r_fwd_a, r_fwd_b;
    logic [MAX_COLORS-1:0] r_fwd_row_a, r_fwd_row_b;

    logic [CW-1:0] r_highest, n_highest;

    // result register
    logic              r_out_vld, n_out_vld;
    logic [OW-1:0]     r_out_color, out_color;
    logic [OW-1:0]     r_out_index, out_index;
    gec_pkg::t_status  r_out_status, out_status;

    // one issue per read stage slot keeps the forwarding one deep
    assign pop      = i_op_vld && !r_s1_vld;
    assign o_op_rdy = !r_s1_vld;

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_rd_a <= mem[AW'(i_op.vertex_a)];
            r_rd_b <= mem[AW'(i_op.vertex_b)];
        end
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // read stage: unwritten rows read as empty, newest rows forwarded
    always_comb begin
        s1_row_a = r_row_vld[r_s1_a] ? r_rd_a : '0;
        s1_row_b = r_row_vld[r_s1_b] ? r_rd_b : '0;
        if (r_fwd_vld && r_fwd_a == r_s1_a) begin
            s1_row_a = r_fwd_row_a;
        end else if (r_fwd_vld && r_fwd_b == r_s1_a) begin
            s1_row_a = r_fwd_row_b;
        end
        if (r_fwd_vld && r_fwd_a == r_s1_b) begin
            s1_row_b = r_fwd_row_a;
        end else if (r_fwd_vld && r_fwd_b == r_s1_b) begin
            s1_row_b = r_fwd_row_b;
        end
        s1_free     = ~(s1_row_a | s1_row_b);
        s1_free_pad = PADW'(s1_free);   // padding bits count as taken
    end

    // first free colour within each group of sixteen
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            grp_any[g] = |s1_free_pad[g*GRP +: GRP];
            grp_idx[g] = '0;
            for (int j = GRP - 1; j >= 0; j--) begin
                if (s1_free_pad[g*GRP + j]) begin
                    grp_idx[g] = GIW'(j);
                end
            end
        end
    end

    // enter resolve only once it is empty, so forwarding is up to date
    assign s1_go = r_s1_vld && !r_s2_vld;

    // resolve stage: lowest group with a free colour
    always_comb begin
        s2_found = 1'b0;
        s2_sel   = '0;
        for (int g = NG - 1; g >= 0; g--) begin
            if (r_s2_any[g]) begin
                s2_found = 1'b1;
                s2_sel   = NGW'(g);
            end
        end
        s2_color_m1 = {s2_sel, r_s2_idx[s2_sel]};
        s2_color    = CW'(s2_color_m1) + CW'(1);
        s2_mask     = MAX_COLORS'(1) << s2_color_m1;
    end

    assign s2_go        = r_s2_vld && (!r_out_vld || o_result.ready);
    assign commit_edge  = s2_go && (r_s2_kind == gec_pkg::K_EDGE) && s2_found;
    assign commit_clear = s2_go && (r_s2_kind == gec_pkg::K_CLEAR);

    always_comb begin
        n_highest  = r_highest;
        out_color  = '0;
        out_status = gec_pkg::ST_REJECTED;
        case (r_s2_kind)
            gec_pkg::K_CLEAR: begin
                n_highest  = '0;
                out_status = gec_pkg::ST_CLEARED;
            end
            gec_pkg::K_EDGE: begin
                if (s2_found) begin
                    out_color  = OW'(s2_color);
                    out_status = gec_pkg::ST_COLORED;
                    if (s2_color > r_highest) begin
                        n_highest = s2_color;
                    end
                end
            end
            default: begin
                out_status = gec_pkg::ST_REJECTED;
            end
        endcase
        out_index = OW'(n_highest);
    end

    // row a is written on commit, row b in the following cycle
    always_comb begin
        wr_en   = commit_edge || r_s3_vld;
        wr_addr = commit_edge ? r_s2_a : r_fwd_b;
        wr_data = commit_edge ? (r_s2_row_a | s2_mask) : r_fwd_row_b;
    end

    always_comb begin
        n_row_vld = r_row_vld;
        if (commit_clear) begin
            n_row_vld = '0;
        end
        if (commit_edge) begin
            n_row_vld[r_s2_a] = 1'b1;
        end
        if (r_s3_vld) begin
            n_row_vld[r_fwd_b] = 1'b1;
        end
        n_fwd_vld = commit_clear ? 1'b0 : (commit_edge ? 1'b1 : r_fwd_vld);
        n_s3_vld  = commit_edge;
        n_s1_vld  = pop ? 1'b1 : (s1_go ? 1'b0 : r_s1_vld);
        n_s2_vld  = s1_go ? 1'b1 : (s2_go ? 1'b0 : r_s2_vld);
        n_out_vld = s2_go ? 1'b1 : (o_result.ready ? 1'b0 : r_out_vld);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_fwd_vld <= 1'b0;
            r_out_vld <= 1'b0;
            r_row_vld <= '0;
            r_highest <= '0;
        end else begin
            r_s1_vld  <= n_s1_vld;
            r_s2_vld  <= n_s2_vld;
            r_s3_vld  <= n_s3_vld;
            r_fwd_vld <= n_fwd_vld;
            r_out_vld <= n_out_vld;
            r_row_vld <= n_row_vld;
            if (s2_go) begin
                r_highest <= n_highest;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_s1_kind <= i_op.kind;
            r_s1_a    <= AW'(i_op.vertex_a);
            r_s1_b    <= AW'(i_op.vertex_b);
        end
        if (s1_go) begin
            r_s2_kind  <= r_s1_kind;
            r_s2_a     <= r_s1_a;
            r_s2_b     <= r_s1_b;
            r_s2_row_a <= s1_row_a;
            r_s2_row_b <= s1_row_b;
            for (int g = 0; g < NG; g++) begin
                r_s2_any[g] <= grp_any[g];
                r_s2_idx[g] <= grp_idx[g];
            end
        end
        if (commit_edge) begin
            r_fwd_a     <= r_s2_a;
            r_fwd_b     <= r_s2_b;
            r_fwd_row_a <= r_s2_row_a | s2_mask;
            r_fwd_row_b <= r_s2_row_b | s2_mask;
        end
        if (s2_go) begin
            r_out_color  <= out_color;
            r_out_index  <= out_index;
            r_out_status <= out_status;
        end
    end

    assign o_result.valid           = r_out_vld;
    assign o_result.edge_color      = r_out_color;
    assign o_result.chromatic_index = r_out_index;
    assign o_result.status          = r_out_status;

    `GEC_ASSERT_SAME(a_single_row_write, i_clk, i_rst_n, commit_edge, !r_s3_vld, "two row writes in one cycle")
    `GEC_ASSERT_SAME(a_colour_free, i_clk, i_rst_n, commit_edge, ((r_s2_row_a | r_s2_row_b) & s2_mask) == '0, "chosen colour already used")
    `GEC_ASSERT_SAME(a_colour_bounded, i_clk, i_rst_n, commit_edge, (s2_color != '0) && (s2_color <= n_highest), "colour outside index")
    `GEC_ASSERT_NEXT(a_clear_empties, i_clk, i_rst_n, commit_clear, (r_row_vld == '0) && (r_highest == '0), "clear left colour state")

endmodule

// ----- hdl/greedy_edge_coloring_top.sv -----
// Path: queue, read stage, resolve stage, then the result register on o_result.
// An op enters resolve only when it is empty; each edge writes two bitmap rows back
// through the single memory write port. Clears and rejects use the same slots.
// Reset: synchronous, active low; bitmap rows are invalidated at once through
// per-vertex valid flags, so the block takes edges straight after reset.
module greedy_edge_coloring_top #(
    parameter int MAX_VERTICES = gec_pkg::MAX_VERTICES_DEF,
    parameter int MAX_COLORS   = gec_pkg::MAX_COLORS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    gec_in_if.sink    i_edge,
    gec_out_if.source o_result
);

    // Front end: sorts each transfer into clear, edge or reject (self loop or
    // vertex beyond the table). Rejects still travel down the pipe so that
    // results keep the input order.
    logic         front_vld;
    gec_pkg::t_op front_op;
    logic         front_rdy;

    // Queue output towards the back end.
    logic         queue_vld;
    gec_pkg::t_op queue_op;
    logic         queue_rdy;

    gec_front #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_front (
        .i_edge   (i_edge),
        .o_op_vld (front_vld),
        .o_op     (front_op),
        .i_op_rdy (front_rdy)
    );

    // Two-entry queue: the front keeps taking transfers while the back end is
    // mid-way through a read-modify-write or the result register is stalled.
    gec_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_vld (front_vld),
        .i_push_op  (front_op),
        .o_push_rdy (front_rdy),
        .o_pop_vld  (queue_vld),
        .o_pop_op   (queue_op),
        .i_pop_rdy  (queue_rdy)
    );

    // Back end: read both endpoint rows, find the lowest colour free at both
    // ends in 16-bit groups, then pick the group and write the two rows back.
    // The last written pair is forwarded so a following edge sees it at once.
    gec_back #(
        .MAX_VERTICES (MAX_VERTICES),
        .MAX_COLORS   (MAX_COLORS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op_vld (queue_vld),
        .i_op     (queue_op),
        .o_op_rdy (queue_rdy),
        .o_result (o_result)
    );

endmodule
